[rtl/ztc_pkg.sv]
package ztc_pkg;

	// Width of the internal row and column counts (holds up to 1023).
	localparam int CNT_W  = 10;
	localparam int PROD_W = 2 * CNT_W;

	localparam int PADDR_W   = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [1:0] MODE_DRAW  = 2'd0;
	localparam logic [1:0] MODE_SCAN  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic [2:0] STAT_WRITTEN = 3'd0;
	localparam logic [2:0] STAT_CLIPPED = 3'd1;
	localparam logic [2:0] STAT_HIDDEN  = 3'd2;
	localparam logic [2:0] STAT_SCANNED = 3'd3;
	localparam logic [2:0] STAT_CLEARED = 3'd4;
	localparam logic [2:0] STAT_BAD     = 3'd5;

	localparam logic [REG_IDX_W-1:0] REG_ROWS    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COLS    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_TMODE   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_FGCOLOR = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BGCOLOR = 3'd4;

	localparam logic [6:0] RST_ROWS  = 7'd24;
	localparam logic [8:0] RST_COLS  = 9'd80;
	localparam logic [6:0] RST_TMODE = 7'd0;
	localparam logic [6:0] RST_FG    = 7'd37;
	localparam logic [6:0] RST_BG    = 7'd40;

	localparam logic [7:0] EMPTY_CHAR = 8'h00;
	localparam logic [7:0] SPACE_CHAR = 8'h20;

	typedef struct packed {
		logic [6:0] text_mode;
		logic [6:0] fg_color;
		logic [6:0] bg_color;
	} look_t;

	localparam look_t RESET_LOOK = '{text_mode: RST_TMODE, fg_color: RST_FG, bg_color: RST_BG};

	typedef struct packed {
		logic [7:0] glyph;
		look_t      look;
		logic [7:0] depth;
	} entry_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [9:0] origin_row;
		logic [9:0] origin_col;
		logic [7:0] image_row;
		logic [7:0] image_col;
		logic [7:0] glyph;
		logic [6:0] text_mode;
		logic [6:0] fg_color;
		logic [6:0] bg_color;
		logic [7:0] layer;
		logic [6:0] end_row;
		logic [8:0] end_col;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] out_glyph;
		logic [6:0] out_text_mode;
		logic [6:0] out_fg_color;
		logic [6:0] out_bg_color;
		logic       style_change;
		logic       screen_end;
	} rsp_t;

	typedef struct packed {
		logic [6:0] rows_in_use;
		logic [8:0] cols_in_use;
		logic [6:0] reset_text_mode;
		logic [6:0] reset_fg_color;
		logic [6:0] reset_bg_color;
	} cfg_t;

endpackage

[rtl/ztc_cmd_if.sv]
interface ztc_cmd_if;
	import ztc_pkg::*;

	logic valid;
	logic ready;
	cmd_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/ztc_rsp_if.sv]
interface ztc_rsp_if;
	import ztc_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/ztc_regs.sv]
module ztc_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ztc_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output ztc_pkg::cfg_t               cfg
);
	import ztc_pkg::*;

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows_in_use     <= RST_ROWS;
			cfg_q.cols_in_use     <= RST_COLS;
			cfg_q.reset_text_mode <= RST_TMODE;
			cfg_q.reset_fg_color  <= RST_FG;
			cfg_q.reset_bg_color  <= RST_BG;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ROWS:    cfg_q.rows_in_use     <= pwdata[6:0];
				REG_COLS:    cfg_q.cols_in_use     <= pwdata[8:0];
				REG_TMODE:   cfg_q.reset_text_mode <= pwdata[6:0];
				REG_FGCOLOR: cfg_q.reset_fg_color  <= pwdata[6:0];
				REG_BGCOLOR: cfg_q.reset_bg_color  <= pwdata[6:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ROWS:    prdata = {25'd0, cfg_q.rows_in_use};
			REG_COLS:    prdata = {23'd0, cfg_q.cols_in_use};
			REG_TMODE:   prdata = {25'd0, cfg_q.reset_text_mode};
			REG_FGCOLOR: prdata = {25'd0, cfg_q.reset_fg_color};
			REG_BGCOLOR: prdata = {25'd0, cfg_q.reset_bg_color};
			default:     prdata = 32'd0;
		endcase
	end
endmodule

[rtl/z_buffered_text_compositor_unit.sv]
// Channel  Dir  Beat    Contents
// cmd      in   cmd_t   mode, draw origin and image position, glyph, style, layer, clear ends
// rsp      out  rsp_t   status, scanned glyph and style, style_change, screen_end
// apb      in   32 bit  rows_in_use, cols_in_use, default text mode, fg and bg color
//
// Draw and scan read the cell in the accept cycle; S_RMW writes it back unless a draw is hidden.
// A clear of R rows by C columns makes one cell write per cycle.
// Clipped draws, bad rectangles and unused modes go through S_RESP and leave the memory alone.
// After reset a clearing pass writes every cell with cmd.ready low; register writes
// are taken meanwhile.
// A waiting result lets the next command in but stalls that command's final cycle.
module z_buffered_text_compositor_unit #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ztc_cmd_if.sink                     cmd,
	ztc_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ztc_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import ztc_pkg::*;

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SIZE_W = $clog2(DEPTH + 1);

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_RMW   = 3'd2;
	localparam logic [2:0] S_CLEAR = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col, input logic [CNT_W-1:0] ncols);
		logic [PROD_W-1:0] full;
		full = PROD_W'(row) * PROD_W'(ncols) + PROD_W'(col);
		return full[ADDR_W-1:0];
	endfunction

	cfg_t cfg;

	ztc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Effective screen size with the size registers clamped to the supported range.
	logic [CNT_W-1:0]  rows_raw, cols_raw, rows_eff, cols_eff;
	logic [PROD_W-1:0] size_full;
	logic [SIZE_W-1:0] size;
	look_t             dflt_look;

	assign rows_raw  = CNT_W'(cfg.rows_in_use);
	assign cols_raw  = CNT_W'(cfg.cols_in_use);
	assign rows_eff  = (rows_raw == '0) ? CNT_W'(1) :
		((rows_raw > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_raw);
	assign cols_eff  = (cols_raw == '0) ? CNT_W'(1) :
		((cols_raw > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : cols_raw);
	assign size_full = PROD_W'(rows_eff) * PROD_W'(cols_eff);
	assign size      = size_full[SIZE_W-1:0];

	assign dflt_look.text_mode = cfg.reset_text_mode;
	assign dflt_look.fg_color  = cfg.reset_fg_color;
	assign dflt_look.bg_color  = cfg.reset_bg_color;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] init_q;
	logic [ADDR_W-1:0] scan_q;
	look_t             last_look_q;
	logic              out_valid_q;
	rsp_t              out_q;

	logic [1:0]        op_q;
	logic [ADDR_W-1:0] idx_q;
	entry_t            new_q;
	logic [2:0]        stat_q;
	logic [ROW_W-1:0]  cr_q, rlast_q;
	logic [COL_W-1:0]  cc_q, cstart_q, clast_q;

	logic acc, out_free;

	assign cmd.ready = (state_q == S_IDLE);
	assign acc       = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// Draw position; bit 10 is the sign of the sum.
	logic [10:0]       dr, dc;
	logic              draw_hit;
	logic [ADDR_W-1:0] draw_addr;

	assign dr = {cmd.data.origin_row[9], cmd.data.origin_row} + {3'b000, cmd.data.image_row};
	assign dc = {cmd.data.origin_col[9], cmd.data.origin_col} + {3'b000, cmd.data.image_col};
	assign draw_hit  = !dr[10] && (dr[9:0] < rows_eff) && !dc[10] && (dc[9:0] < cols_eff);
	assign draw_addr = cell_addr(dr[ROW_W-1:0], dc[COL_W-1:0], cols_eff);

	// Clear rectangle check.
	logic [CNT_W-1:0] orow10, ocol10, er10, ec10, er_m1, ec_m1;
	logic             clr_ok;

	assign orow10 = cmd.data.origin_row;
	assign ocol10 = cmd.data.origin_col;
	assign er10   = {3'b000, cmd.data.end_row};
	assign ec10   = {1'b0, cmd.data.end_col};
	assign er_m1  = er10 - CNT_W'(1);
	assign ec_m1  = ec10 - CNT_W'(1);
	assign clr_ok = !orow10[9] && !ocol10[9] && (orow10 < er10) && (er10 <= rows_eff)
		&& (ocol10 < ec10) && (ec10 <= cols_eff);

	// Scan restarts at cell 0 when a size change left it past the screen.
	logic [ADDR_W-1:0] scan_start;
	assign scan_start = (SIZE_W'(scan_q) >= size) ? '0 : scan_q;

	// Cell memory.
	entry_t            mem [0:DEPTH-1];
	entry_t            rdata_q;
	logic              mem_re, mem_we;
	logic [ADDR_W-1:0] mem_raddr, mem_waddr;
	entry_t            mem_wdata;

	assign mem_re    = acc && (((cmd.data.mode == MODE_DRAW) && draw_hit)
		|| (cmd.data.mode == MODE_SCAN));
	assign mem_raddr = (cmd.data.mode == MODE_SCAN) ? scan_start : draw_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	entry_t fix_entry;
	logic   hidden, scan_last;

	always_comb begin
		fix_entry = rdata_q;
		if (rdata_q.glyph == EMPTY_CHAR) begin
			fix_entry.glyph = SPACE_CHAR;
		end
	end

	assign hidden    = new_q.depth < rdata_q.depth;
	assign scan_last = (SIZE_W'(idx_q) + SIZE_W'(1)) == size;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = new_q;
		case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = init_q;
				mem_wdata = '{glyph: EMPTY_CHAR, look: RESET_LOOK, depth: 8'd0};
			end
			S_RMW: begin
				mem_we    = out_free && ((op_q == MODE_SCAN) || !hidden);
				mem_wdata = (op_q == MODE_SCAN) ? fix_entry : new_q;
			end
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cell_addr(cr_q, cc_q, cols_eff);
				mem_wdata = '{glyph: EMPTY_CHAR, look: dflt_look, depth: 8'd0};
			end
			default: begin
			end
		endcase
	end

	logic load_out;
	rsp_t out_next;

	always_comb begin
		load_out = 1'b0;
		out_next = '0;
		case (state_q)
			S_RMW: begin
				load_out = out_free;
				if (op_q == MODE_SCAN) begin
					out_next.status        = STAT_SCANNED;
					out_next.out_glyph     = fix_entry.glyph;
					out_next.out_text_mode = rdata_q.look.text_mode;
					out_next.out_fg_color  = rdata_q.look.fg_color;
					out_next.out_bg_color  = rdata_q.look.bg_color;
					out_next.style_change  = (idx_q == '0) || (rdata_q.look != last_look_q);
					out_next.screen_end    = scan_last;
				end else begin
					out_next.status = hidden ? STAT_HIDDEN : STAT_WRITTEN;
				end
			end
			S_RESP: begin
				load_out        = out_free;
				out_next.status = stat_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_q      <= '0;
			scan_q      <= '0;
			last_look_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					init_q <= init_q + ADDR_W'(1);
					if (init_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc) begin
						case (cmd.data.mode)
							MODE_DRAW:  state_q <= draw_hit ? S_RMW : S_RESP;
							MODE_SCAN:  state_q <= S_RMW;
							MODE_CLEAR: state_q <= clr_ok ? S_CLEAR : S_RESP;
							default:    state_q <= S_RESP;
						endcase
					end
				end
				S_RMW: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (op_q == MODE_SCAN) begin
							scan_q      <= scan_last ? '0 : idx_q + ADDR_W'(1);
							last_look_q <= rdata_q.look;
						end
					end
				end
				S_CLEAR: begin
					if ((cc_q == clast_q) && (cr_q == rlast_q)) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= out_next;
		end
		if (acc) begin
			op_q           <= cmd.data.mode;
			new_q.glyph    <= cmd.data.glyph;
			new_q.look     <= '{text_mode: cmd.data.text_mode, fg_color: cmd.data.fg_color,
				bg_color: cmd.data.bg_color};
			new_q.depth    <= cmd.data.layer;
			idx_q          <= (cmd.data.mode == MODE_SCAN) ? scan_start : draw_addr;
			cr_q           <= orow10[ROW_W-1:0];
			cc_q           <= ocol10[COL_W-1:0];
			cstart_q       <= ocol10[COL_W-1:0];
			rlast_q        <= er_m1[ROW_W-1:0];
			clast_q        <= ec_m1[COL_W-1:0];
			case (cmd.data.mode)
				MODE_DRAW:  stat_q <= STAT_CLIPPED;
				MODE_CLEAR: stat_q <= clr_ok ? STAT_CLEARED : STAT_BAD;
				default:    stat_q <= STAT_BAD;
			endcase
		end else if (state_q == S_CLEAR) begin
			// Walk the rectangle row by row.
			if (cc_q == clast_q) begin
				cc_q <= cstart_q;
				cr_q <= cr_q + ROW_W'(1);
			end else begin
				cc_q <= cc_q + COL_W'(1);
			end
		end
	end
endmodule

[rtl/ztc_check.sv]
module ztc_check (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input ztc_pkg::rsp_t rsp_data
);
	import ztc_pkg::*;

	// Commands accepted whose results have not yet been taken.
	logic [1:0] pend_q;
	logic       cmd_beat, rsp_beat;

	assign cmd_beat = cmd_valid && cmd_ready;
	assign rsp_beat = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else if (cmd_beat && !rsp_beat) begin
			pend_q <= pend_q + 2'd1;
		end else if (rsp_beat && !cmd_beat) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two commands outstanding");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("result without an outstanding command");

	a_scan_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status == STAT_SCANNED) |-> rsp_data.out_glyph != EMPTY_CHAR)
		else $error("scanned cell shows an empty glyph");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status != STAT_SCANNED)
		|-> (rsp_data.out_glyph == 8'd0) && (rsp_data.out_text_mode == 7'd0)
		&& (rsp_data.out_fg_color == 7'd0) && (rsp_data.out_bg_color == 7'd0)
		&& !rsp_data.style_change && !rsp_data.screen_end)
		else $error("non-scan result carries cell fields");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled result beat changed");
endmodule

bind z_buffered_text_compositor_unit ztc_check u_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
